### hdl/gpio_ev_pkg.sv
`default_nettype none

package gpio_ev_pkg;

    localparam int IO_W          = 54;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;
    localparam int FUNC_WORDS    = 7;
    localparam int PINS_PER_WORD = 10;
    localparam int NUM_EVENTS    = 6;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic [IDX_W-1:0]   reg_index;
        logic [DATA_W-1:0]  write_data;
        logic [IO_W-1:0]    pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [IO_W-1:0]    drive_level;
        logic [IO_W-1:0]    drive_enable;
        logic [IO_W-1:0]    pull_up_pins;
        logic [IO_W-1:0]    pull_down_pins;
        logic               event_pending;
    } t_out_item;

    // register word map
    localparam logic [IDX_W-1:0] OFS_SET     = 6'h07;
    localparam logic [IDX_W-1:0] OFS_CLR     = 6'h0A;
    localparam logic [IDX_W-1:0] OFS_LEVEL   = 6'h0D;
    localparam logic [IDX_W-1:0] OFS_STATUS  = 6'h10;
    localparam logic [IDX_W-1:0] OFS_PULL    = 6'h25;
    localparam logic [IDX_W-1:0] OFS_PULLCLK = 6'h26;

    // event enable banks: rising, falling, high, low, async rising, async falling
    localparam int EV_RISE   = 0;
    localparam int EV_FALL   = 1;
    localparam int EV_HIGH   = 2;
    localparam int EV_LOW    = 3;
    localparam int EV_ARISE  = 4;
    localparam int EV_AFALL  = 5;
    localparam logic [IDX_W-1:0] EN_BASE [NUM_EVENTS] = '{
        6'h13, 6'h16, 6'h19, 6'h1C, 6'h1F, 6'h22
    };

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;
    localparam logic [1:0] PULL_DOWN   = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd2;

endpackage

`default_nettype wire

### hdl/gpio_bank_with_event_detect.sv
`default_nettype none

// channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_in_data  (gpio_ev_pkg::t_in_item)
// output  | o_out_valid| i_out_ready | o_out_data (gpio_ev_pkg::t_out_item)
//
// one beat per clock in each direction while the output is not stalled; every input beat gives one output beat
// a beat passes the input register, then register update and result register
// reset (i_rst_n low at a clock edge) empties both stages and returns all pins to
// input, no pull, latch, samples, enables and status cleared
// a stalled output holds its beat; the input register still takes a beat while it is
// empty or the output stage is free or being drained in the same cycle

module gpio_bank_with_event_detect #(
    parameter int NUM_PINS = 54
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  gpio_ev_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output gpio_ev_pkg::t_out_item o_out_data
);

    localparam int NE = gpio_ev_pkg::NUM_EVENTS;

    // pipeline registers
    logic                   r_in_valid;
    gpio_ev_pkg::t_in_item  r_in;
    logic                   r_out_valid;
    gpio_ev_pkg::t_out_item r_out;
    gpio_ev_pkg::t_out_item n_out;

    // architectural state and its next values
    logic [2:0]          r_fsel     [NUM_PINS];
    logic [2:0]          n_fsel     [NUM_PINS];
    logic [1:0]          r_pull     [NUM_PINS];
    logic [1:0]          n_pull     [NUM_PINS];
    logic [NUM_PINS-1:0] r_en       [NE];
    logic [NUM_PINS-1:0] n_en       [NE];
    logic [NUM_PINS-1:0] r_latch,   n_latch;
    logic [NUM_PINS-1:0] r_level,   n_level;
    logic [NUM_PINS-1:0] r_prev,    n_prev;
    logic [NUM_PINS-1:0] r_status,  n_status;
    logic [1:0]          r_pull_ctl, n_pull_ctl;

    logic                        in_acc;
    logic                        advance;
    logic [31:0]                 fsel_word [gpio_ev_pkg::FUNC_WORDS];
    logic [31:0]                 rd;
    logic [5:0]                  idx;
    logic [31:0]                 wdata;
    logic [NUM_PINS-1:0]         cur, rise, fall, ev;
    logic [NUM_PINS-1:0]         en_v, up_v, dn_v;
    logic [NUM_PINS-1:0]         pclk_hit;
    logic [63:0]                 pins64;

    // upper or lower 32 pins of a bank word, clipped to the pin count
    function automatic logic [NUM_PINS-1:0] word_bits(logic [31:0] d, logic hi);
        logic [63:0] t;
        t = hi ? {d, 32'b0} : {32'b0, d};
        return t[NUM_PINS-1:0];
    endfunction

    function automatic logic [31:0] word_get(logic [NUM_PINS-1:0] v, logic hi);
        logic [63:0] t;
        t = 64'(v);
        return hi ? t[63:32] : t[31:0];
    endfunction

    function automatic logic [gpio_ev_pkg::IO_W-1:0] to_out(logic [NUM_PINS-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[gpio_ev_pkg::IO_W-1:0];
    endfunction

    // the input stage empties when its beat moves to the result stage
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // function select readback words, 3 bits per pin, 10 pins per word
    always_comb begin
        for (int w = 0; w < gpio_ev_pkg::FUNC_WORDS; w++) begin
            fsel_word[w] = '0;
            for (int k = 0; k < gpio_ev_pkg::PINS_PER_WORD; k++) begin
                if (w * gpio_ev_pkg::PINS_PER_WORD + k < NUM_PINS) begin
                    fsel_word[w][3*k +: 3] = r_fsel[w * gpio_ev_pkg::PINS_PER_WORD + k];
                end
            end
        end
    end

    // one item: state update and result from the updated state
    always_comb begin
        n_fsel     = r_fsel;
        n_pull     = r_pull;
        n_en       = r_en;
        n_latch    = r_latch;
        n_level    = r_level;
        n_prev     = r_prev;
        n_status   = r_status;
        n_pull_ctl = r_pull_ctl;
        rd         = '0;
        idx        = r_in.reg_index;
        wdata      = r_in.write_data;
        pclk_hit   = word_bits(wdata, idx == gpio_ev_pkg::OFS_PULLCLK + 6'd1);
        pins64     = 64'(r_in.pin_levels);
        cur        = pins64[NUM_PINS-1:0];
        rise       = cur & ~r_level;
        fall       = ~cur & r_level;
        ev         = (rise & r_en[gpio_ev_pkg::EV_RISE])  | (fall & r_en[gpio_ev_pkg::EV_FALL])
                   | (cur  & r_en[gpio_ev_pkg::EV_HIGH])  | (~cur & r_en[gpio_ev_pkg::EV_LOW])
                   | (rise & r_en[gpio_ev_pkg::EV_ARISE]) | (fall & r_en[gpio_ev_pkg::EV_AFALL]);

        case (r_in.req_type)
            gpio_ev_pkg::REQ_READ: begin
                if (idx < 6'(gpio_ev_pkg::FUNC_WORDS)) begin
                    rd = fsel_word[idx[2:0]];
                end else if (idx == gpio_ev_pkg::OFS_LEVEL
                          || idx == gpio_ev_pkg::OFS_LEVEL + 6'd1) begin
                    rd = word_get(r_level, idx == gpio_ev_pkg::OFS_LEVEL + 6'd1);
                end else if (idx == gpio_ev_pkg::OFS_STATUS
                          || idx == gpio_ev_pkg::OFS_STATUS + 6'd1) begin
                    rd = word_get(r_status, idx == gpio_ev_pkg::OFS_STATUS + 6'd1);
                end else if (idx == gpio_ev_pkg::OFS_PULL) begin
                    rd = 32'(r_pull_ctl);
                end
                for (int e = 0; e < NE; e++) begin
                    if (idx == gpio_ev_pkg::EN_BASE[e]
                        || idx == gpio_ev_pkg::EN_BASE[e] + 6'd1) begin
                        rd = word_get(r_en[e], idx == gpio_ev_pkg::EN_BASE[e] + 6'd1);
                    end
                end
            end
            gpio_ev_pkg::REQ_WRITE: begin
                for (int w = 0; w < gpio_ev_pkg::FUNC_WORDS; w++) begin
                    for (int k = 0; k < gpio_ev_pkg::PINS_PER_WORD; k++) begin
                        if (w * gpio_ev_pkg::PINS_PER_WORD + k < NUM_PINS
                            && idx == 6'(w)) begin
                            n_fsel[w * gpio_ev_pkg::PINS_PER_WORD + k] = wdata[3*k +: 3];
                        end
                    end
                end
                if (idx == gpio_ev_pkg::OFS_SET || idx == gpio_ev_pkg::OFS_SET + 6'd1) begin
                    n_latch = r_latch | word_bits(wdata, idx == gpio_ev_pkg::OFS_SET + 6'd1);
                end
                if (idx == gpio_ev_pkg::OFS_CLR || idx == gpio_ev_pkg::OFS_CLR + 6'd1) begin
                    n_latch = r_latch & ~word_bits(wdata, idx == gpio_ev_pkg::OFS_CLR + 6'd1);
                end
                // status is write 1 to clear
                if (idx == gpio_ev_pkg::OFS_STATUS
                    || idx == gpio_ev_pkg::OFS_STATUS + 6'd1) begin
                    n_status = r_status
                             & ~word_bits(wdata, idx == gpio_ev_pkg::OFS_STATUS + 6'd1);
                end
                for (int e = 0; e < NE; e++) begin
                    if (idx == gpio_ev_pkg::EN_BASE[e]
                        || idx == gpio_ev_pkg::EN_BASE[e] + 6'd1) begin
                        n_en[e] = (r_en[e]
                                & ~word_bits(32'hFFFF_FFFF,
                                             idx == gpio_ev_pkg::EN_BASE[e] + 6'd1))
                                | word_bits(wdata, idx == gpio_ev_pkg::EN_BASE[e] + 6'd1);
                    end
                end
                if (idx == gpio_ev_pkg::OFS_PULL) begin
                    n_pull_ctl = wdata[1:0];
                end
                // pull clock: each set bit latches the pull control into that pin
                if (idx == gpio_ev_pkg::OFS_PULLCLK
                    || idx == gpio_ev_pkg::OFS_PULLCLK + 6'd1) begin
                    for (int p = 0; p < NUM_PINS; p++) begin
                        if (pclk_hit[p]) begin
                            n_pull[p] = r_pull_ctl;
                        end
                    end
                end
            end
            gpio_ev_pkg::REQ_TICK: begin
                // edges compare the new sample with the one before it
                n_prev   = r_level;
                n_level  = cur;
                n_status = r_status | ev;
            end
            default: begin
            end
        endcase

        for (int p = 0; p < NUM_PINS; p++) begin
            en_v[p] = (n_fsel[p] == gpio_ev_pkg::FSEL_OUTPUT);
            up_v[p] = (n_pull[p] == gpio_ev_pkg::PULL_UP);
            dn_v[p] = (n_pull[p] == gpio_ev_pkg::PULL_DOWN);
        end

        n_out.read_data      = rd;
        n_out.drive_level    = to_out(n_latch);
        n_out.drive_enable   = to_out(en_v);
        n_out.pull_up_pins   = to_out(up_v);
        n_out.pull_down_pins = to_out(dn_v);
        n_out.event_pending  = |n_status;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_latch     <= '0;
            r_level     <= '0;
            r_prev      <= '0;
            r_status    <= '0;
            r_pull_ctl  <= '0;
            for (int p = 0; p < NUM_PINS; p++) begin
                r_fsel[p] <= '0;
                r_pull[p] <= '0;
            end
            for (int e = 0; e < NE; e++) begin
                r_en[e] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_fsel     <= n_fsel;
                r_pull     <= n_pull;
                r_en       <= n_en;
                r_latch    <= n_latch;
                r_level    <= n_level;
                r_prev     <= n_prev;
                r_status   <= n_status;
                r_pull_ctl <= n_pull_ctl;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### hdl/gpio_ev_chk.sv
`default_nettype none

module gpio_ev_chk (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    i_in_ready,
    input wire                    i_out_valid,
    input wire                    i_out_ready,
    input gpio_ev_pkg::t_out_item i_out_data
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output beat changed while stalled");

    // input side only backs up when the output side is stalled
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while output stage free");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a beat taken with an empty output stage passes the input and result registers to the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid && $past(i_in_ready) && i_out_ready
        ##1 i_out_ready |=> i_out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind gpio_bank_with_event_detect gpio_ev_chk u_gpio_ev_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // sizes taken from the package
    localparam int IO_W          = gpio_ev_pkg::IO_W;
    localparam int DATA_W        = gpio_ev_pkg::DATA_W;
    localparam int IDX_W         = gpio_ev_pkg::IDX_W;
    localparam int FUNC_WORDS    = gpio_ev_pkg::FUNC_WORDS;
    localparam int PINS_PER_WORD = gpio_ev_pkg::PINS_PER_WORD;
    localparam int NUM_EVENTS    = gpio_ev_pkg::NUM_EVENTS;

    // run limits and stimulus sizes
    localparam int LIMIT_CYCLES = 200_000;
    localparam int RANDOM_BEATS = 1200;
    localparam int DRAIN_AT     = 500;   // random beat before which the sender waits for quiet
    localparam int HOLD_AT      = 300;   // results seen before the long output hold-off
    localparam int HOLD_CYCLES  = 200;
    localparam int CALM_LO      = 700;   // no idling on either side inside this window
    localparam int CALM_HI      = 900;
    localparam int MAX_PRINTS   = 40;

    // register words the package does not name
    localparam logic [IDX_W-1:0] FSEL_BASE    = 6'h00;
    localparam logic [IDX_W-1:0] IDX_UNMAPPED = 6'h3F;
    // request code outside the enum, treated as a no-op
    localparam logic [1:0] REQ_NONE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    gpio_ev_pkg::t_in_item  in_data = '0;
    logic                   out_ready = 1'b0;
    wire                    in_ready;
    wire                    out_valid;
    gpio_ev_pkg::t_out_item out_data;

    gpio_bank_with_event_detect dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // 20 ns period
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // shadow copy of the register block
    // ------------------------------------------------------------------
    logic [2:0]      shadow_fsel [IO_W];
    logic [IO_W-1:0] shadow_latch;
    logic [IO_W-1:0] shadow_level;
    logic [IO_W-1:0] shadow_prev;
    logic [IO_W-1:0] shadow_en [NUM_EVENTS];
    logic [IO_W-1:0] shadow_status;
    logic [1:0]      shadow_pullsel;
    logic [1:0]      shadow_pull [IO_W];

    // pin outputs expected after each accepted beat, oldest first
    gpio_ev_pkg::t_out_item due_outputs[$];

    int mismatches   = 0;
    int results_seen = 0;
    int beats_in     = 0;
    int n_reads      = 0;
    int n_writes     = 0;
    int n_ticks      = 0;
    int n_noops      = 0;
    int cycles       = 0;

    // 0 or 1 for word 0 or 1 of a two-word bank at base, -1 otherwise
    function automatic int bank_of(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] base);
        if (idx == base) return 0;
        if (idx == base + 6'd1) return 1;
        return -1;
    endfunction

    function automatic logic [DATA_W-1:0] word_of(logic [IO_W-1:0] v, int w);
        logic [63:0] wide;
        wide = {{(64-IO_W){1'b0}}, v};
        return (w == 1) ? wide[63:32] : wide[31:0];
    endfunction

    // bus word placed on its pins, bits past the last pin dropped
    function automatic logic [IO_W-1:0] word_field(logic [DATA_W-1:0] d, int w);
        logic [63:0] wide;
        wide = (w == 1) ? {d, 32'h0} : {32'h0, d};
        return wide[IO_W-1:0];
    endfunction

    // applies one beat to the shadow registers, returns the pin outputs after it
    function automatic gpio_ev_pkg::t_out_item apply_beat(gpio_ev_pkg::t_in_item it);
        gpio_ev_pkg::t_out_item r;
        logic [IO_W-1:0]        rise, fall, hit;
        logic [IDX_W-1:0]       idx;
        int                     k, e, pin, w;
        r   = '0;
        idx = it.reg_index;
        case (it.req_type)
            gpio_ev_pkg::REQ_READ: begin
                if (idx < FUNC_WORDS) begin
                    for (k = 0; k < PINS_PER_WORD; k++) begin
                        pin = int'(idx) * PINS_PER_WORD + k;
                        if (pin < IO_W) r.read_data[3*k +: 3] = shadow_fsel[pin];
                    end
                end else if (bank_of(idx, gpio_ev_pkg::OFS_LEVEL) >= 0) begin
                    r.read_data = word_of(shadow_level, bank_of(idx, gpio_ev_pkg::OFS_LEVEL));
                end else if (bank_of(idx, gpio_ev_pkg::OFS_STATUS) >= 0) begin
                    r.read_data = word_of(shadow_status,
                                          bank_of(idx, gpio_ev_pkg::OFS_STATUS));
                end else if (idx == gpio_ev_pkg::OFS_PULL) begin
                    r.read_data = {{(DATA_W-2){1'b0}}, shadow_pullsel};
                end else begin
                    for (e = 0; e < NUM_EVENTS; e++) begin
                        w = bank_of(idx, gpio_ev_pkg::EN_BASE[e]);
                        if (w >= 0) r.read_data = word_of(shadow_en[e], w);
                    end
                end
            end
            gpio_ev_pkg::REQ_WRITE: begin
                if (idx < FUNC_WORDS) begin
                    for (k = 0; k < PINS_PER_WORD; k++) begin
                        pin = int'(idx) * PINS_PER_WORD + k;
                        if (pin < IO_W) shadow_fsel[pin] = it.write_data[3*k +: 3];
                    end
                end else if (bank_of(idx, gpio_ev_pkg::OFS_SET) >= 0) begin
                    shadow_latch |= word_field(it.write_data,
                                               bank_of(idx, gpio_ev_pkg::OFS_SET));
                end else if (bank_of(idx, gpio_ev_pkg::OFS_CLR) >= 0) begin
                    shadow_latch &= ~word_field(it.write_data,
                                                bank_of(idx, gpio_ev_pkg::OFS_CLR));
                end else if (bank_of(idx, gpio_ev_pkg::OFS_STATUS) >= 0) begin
                    shadow_status &= ~word_field(it.write_data,
                                                 bank_of(idx, gpio_ev_pkg::OFS_STATUS));
                end else if (idx == gpio_ev_pkg::OFS_PULL) begin
                    shadow_pullsel = it.write_data[1:0];
                end else if (bank_of(idx, gpio_ev_pkg::OFS_PULLCLK) >= 0) begin
                    hit = word_field(it.write_data, bank_of(idx, gpio_ev_pkg::OFS_PULLCLK));
                    for (pin = 0; pin < IO_W; pin++)
                        if (hit[pin]) shadow_pull[pin] = shadow_pullsel;
                end else begin
                    for (e = 0; e < NUM_EVENTS; e++) begin
                        w = bank_of(idx, gpio_ev_pkg::EN_BASE[e]);
                        if (w >= 0)
                            shadow_en[e] = (shadow_en[e] & ~word_field({DATA_W{1'b1}}, w))
                                         | word_field(it.write_data, w);
                    end
                end
            end
            gpio_ev_pkg::REQ_TICK: begin
                shadow_prev  = shadow_level;
                shadow_level = it.pin_levels;
                rise = shadow_level & ~shadow_prev;
                fall = ~shadow_level & shadow_prev;
                shadow_status |= (rise & shadow_en[gpio_ev_pkg::EV_RISE])
                               | (fall & shadow_en[gpio_ev_pkg::EV_FALL])
                               | (shadow_level & shadow_en[gpio_ev_pkg::EV_HIGH])
                               | (~shadow_level & shadow_en[gpio_ev_pkg::EV_LOW])
                               | (rise & shadow_en[gpio_ev_pkg::EV_ARISE])
                               | (fall & shadow_en[gpio_ev_pkg::EV_AFALL]);
            end
            default: ;
        endcase
        for (pin = 0; pin < IO_W; pin++) begin
            r.drive_enable[pin]   = (shadow_fsel[pin] == gpio_ev_pkg::FSEL_OUTPUT);
            r.pull_up_pins[pin]   = (shadow_pull[pin] == gpio_ev_pkg::PULL_UP);
            r.pull_down_pins[pin] = (shadow_pull[pin] == gpio_ev_pkg::PULL_DOWN);
        end
        r.drive_level   = shadow_latch;
        r.event_pending = |shadow_status;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on %s after %0d results: got %h, expected %h",
                     $time, field, results_seen, got, want);
        mismatches++;
    endtask

    // every beat taken on the output side is held against the oldest expectation
    always @(posedge clk) begin
        gpio_ev_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (due_outputs.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_data.read_data), 64'd0);
            end else begin
                want = due_outputs.pop_front();
                if (out_data.read_data !== want.read_data)
                    report_mismatch("read_data", 64'(out_data.read_data), 64'(want.read_data));
                if (out_data.drive_level !== want.drive_level)
                    report_mismatch("drive_level", 64'(out_data.drive_level),
                                    64'(want.drive_level));
                if (out_data.drive_enable !== want.drive_enable)
                    report_mismatch("drive_enable", 64'(out_data.drive_enable),
                                    64'(want.drive_enable));
                if (out_data.pull_up_pins !== want.pull_up_pins)
                    report_mismatch("pull_up_pins", 64'(out_data.pull_up_pins),
                                    64'(want.pull_up_pins));
                if (out_data.pull_down_pins !== want.pull_down_pins)
                    report_mismatch("pull_down_pins", 64'(out_data.pull_down_pins),
                                    64'(want.pull_down_pins));
                if (out_data.event_pending !== want.event_pending)
                    report_mismatch("event_pending", 64'(out_data.event_pending),
                                    64'(want.event_pending));
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: random back-pressure, one long hold-off, a calm window
    // ------------------------------------------------------------------
    initial begin : out_side
        int  hold_left;
        bit  held_off;
        hold_left = 0;
        held_off  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                // long stall so the pipe fills and input ready drops
                hold_left--;
                out_ready <= 1'b0;
            end else if (!held_off && results_seen >= HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // entered and left at a falling edge; predicts at the accepting rising edge
    task automatic send_beat(input gpio_ev_pkg::t_in_item it, input bit drain_first,
                             input bit typed, input gpio_ev_pkg::t_out_item typed_out);
        gpio_ev_pkg::t_out_item guess;
        bit                     calm;
        calm = (beats_in >= CALM_LO && beats_in < CALM_HI);
        if (drain_first || (!calm && $urandom_range(0, 99) < 10)) begin
            in_valid <= 1'b0;
            @(negedge clk);
            // either wait for every outstanding result or stretch the gap at random
            while (drain_first ? (due_outputs.size() != 0) : ($urandom_range(0, 3) == 0))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        guess = apply_beat(it);
        due_outputs.push_back(typed ? typed_out : guess);
        beats_in++;
        case (it.req_type)
            gpio_ev_pkg::REQ_READ:  n_reads++;
            gpio_ev_pkg::REQ_WRITE: n_writes++;
            gpio_ev_pkg::REQ_TICK:  n_ticks++;
            default:                n_noops++;
        endcase
        @(negedge clk);
    endtask

    // directed rows: beat, plus a typed expectation where it is obvious
    typedef struct {
        gpio_ev_pkg::t_in_item  beat;
        bit                     typed;
        gpio_ev_pkg::t_out_item result;
    } t_dir_row;

    t_dir_row script[$];

    function automatic void add_row(gpio_ev_pkg::t_req rq, logic [IDX_W-1:0] idx,
                                    logic [DATA_W-1:0] d, logic [IO_W-1:0] pins,
                                    bit typed, gpio_ev_pkg::t_out_item res);
        t_dir_row row;
        row.beat.req_type   = rq;
        row.beat.reg_index  = idx;
        row.beat.write_data = d;
        row.beat.pin_levels = pins;
        row.typed  = typed;
        row.result = res;
        script.push_back(row);
    endfunction

    // watchdog
    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycles, due_outputs.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : in_side
        gpio_ev_pkg::t_in_item  beat;
        gpio_ev_pkg::t_out_item fsel_word0;
        logic [IO_W-1:0]        last_pins;
        logic [DATA_W-1:0]      d;
        logic [IDX_W-1:0]       idx;
        int                     i, e;

        // shadow state after reset: all inputs, no pull, everything cleared
        for (i = 0; i < IO_W; i++) begin
            shadow_fsel[i] = '0;
            shadow_pull[i] = '0;
        end
        for (e = 0; e < NUM_EVENTS; e++) shadow_en[e] = '0;
        shadow_latch   = '0;
        shadow_level   = '0;
        shadow_prev    = '0;
        shadow_status  = '0;
        shadow_pullsel = '0;
        last_pins      = '0;

        // all ten selects at 7, the two spare bits of the word read back as zero
        fsel_word0 = '0;
        fsel_word0.read_data = 32'h3FFF_FFFF;

        // reset values first
        add_row(gpio_ev_pkg::REQ_READ,  FSEL_BASE, '0, '0, 1'b1, '0);
        add_row(gpio_ev_pkg::REQ_READ,  gpio_ev_pkg::OFS_PULL, '0, '0, 1'b1, '0);
        // select word extremes, incl. the partial word and the word past the last pin
        add_row(gpio_ev_pkg::REQ_WRITE, FSEL_BASE, '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_READ,  FSEL_BASE, '0, '0, 1'b1, fsel_word0);
        add_row(gpio_ev_pkg::REQ_WRITE, FSEL_BASE + 6'd5, 32'h0924_9249, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_READ,  FSEL_BASE + 6'd5, '0, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, FSEL_BASE + 6'd6, '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_READ,  FSEL_BASE + 6'd6, '0, '0, 1'b0, '0);
        // latch set on both words and clear on the low word, high word beyond pin 53 dropped
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_SET + 6'd1, '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_SET,        '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_CLR, 32'h5555_5555, '0, 1'b0, '0);
        // write to the read-only level word is ignored
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_LEVEL,      '1, '0, 1'b0, '0);
        // a few enables, then edges and levels
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::EN_BASE[gpio_ev_pkg::EV_RISE],
                '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::EN_BASE[gpio_ev_pkg::EV_HIGH] + 6'd1,
                '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::EN_BASE[gpio_ev_pkg::EV_AFALL] + 6'd1,
                '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_TICK,  FSEL_BASE, '0, '1, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_TICK,  FSEL_BASE, '0, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_READ,  gpio_ev_pkg::OFS_LEVEL + 6'd1, '0, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_READ,  gpio_ev_pkg::OFS_STATUS,       '0, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_STATUS,       '1, '0, 1'b0, '0);
        // pull latch: up on the low word, reserved code on a few pins
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_PULL,    32'd2, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_PULLCLK, '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_PULL,    '1, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::REQ_WRITE, gpio_ev_pkg::OFS_PULLCLK, 32'h0000_000F, '0,
                1'b0, '0);
        // unmapped word and the spare request code
        add_row(gpio_ev_pkg::REQ_READ,  IDX_UNMAPPED, '0, '0, 1'b0, '0);
        add_row(gpio_ev_pkg::t_req'(REQ_NONE), gpio_ev_pkg::OFS_PULL, '1, '1, 1'b0, '0);

        // synchronous reset, released at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[s])
            send_beat(script[s].beat, 1'b0, script[s].typed, script[s].result);

        for (i = 0; i < RANDOM_BEATS; i++) begin
            // mostly mapped words, some anywhere in the index space
            case ($urandom_range(0, 9))
                0, 1:    idx = FSEL_BASE + IDX_W'($urandom_range(0, FUNC_WORDS - 1));
                2:       idx = gpio_ev_pkg::OFS_SET + IDX_W'($urandom_range(0, 1));
                3:       idx = gpio_ev_pkg::OFS_CLR + IDX_W'($urandom_range(0, 1));
                4:       idx = gpio_ev_pkg::OFS_LEVEL + IDX_W'($urandom_range(0, 1));
                5:       idx = gpio_ev_pkg::OFS_STATUS + IDX_W'($urandom_range(0, 1));
                6, 7:    idx = gpio_ev_pkg::EN_BASE[$urandom_range(0, NUM_EVENTS - 1)]
                             + IDX_W'($urandom_range(0, 1));
                8:       idx = gpio_ev_pkg::OFS_PULL + IDX_W'($urandom_range(0, 2));
                default: idx = IDX_W'($urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 4))
                0:       d = '1;
                1:       d = '0;
                2:       d = 32'h1 << $urandom_range(0, DATA_W - 1);
                default: d = $urandom();
            endcase
            beat.reg_index  = idx;
            beat.write_data = d;
            // pins: all high, all low, fresh random words or a single toggle for sparse edges
            case ($urandom_range(0, 5))
                0:       beat.pin_levels = '1;
                1:       beat.pin_levels = '0;
                2, 3:    beat.pin_levels = last_pins ^ (IO_W'(1) << $urandom_range(0, IO_W - 1));
                default: beat.pin_levels = IO_W'({$urandom(), $urandom()});
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: beat.req_type = gpio_ev_pkg::REQ_READ;
                4, 5, 6:    beat.req_type = gpio_ev_pkg::REQ_WRITE;
                default: begin
                    beat.req_type = gpio_ev_pkg::REQ_TICK;
                    last_pins     = beat.pin_levels;
                end
            endcase
            send_beat(beat, (i == DRAIN_AT), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // let the pipe empty, then wait on to catch stray results
        while (due_outputs.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("beats sent %0d: %0d reads, %0d writes, %0d ticks, %0d no-ops",
                 beats_in, n_reads, n_writes, n_ticks, n_noops);
        $display("results checked %0d in %0d cycles, %0d mismatches, incl. stall and drain",
                 results_seen, cycles, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
